// ----- hw/rtl/rssc_pkg.sv -----
// Package of shared types, codes and constants for the subset core.
`timescale 1ns / 1ps

package rssc_pkg;

  localparam int unsigned DATA_ADDR_W = 16;
  localparam int unsigned XLEN        = 32;
  localparam int unsigned REG_IDX_W   = 5;
  localparam int unsigned NUM_REGS    = 32;

  localparam logic [XLEN-1:0] HALT_WORD = '1;

  typedef enum logic [1:0] {
    ACT_EXEC  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  typedef enum logic [5:0] {
    OP_RTYPE = 6'b000000,
    OP_J     = 6'b000010,
    OP_LW    = 6'b100011,
    OP_SW    = 6'b101011,
    OP_ADDIU = 6'b001001
  } opcode_e;

  typedef enum logic [2:0] {
    FN_ADDU = 3'd1,
    FN_SUBU = 3'd3,
    FN_AND  = 3'd4,
    FN_OR   = 3'd5,
    FN_NOR  = 3'd7
  } funct_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] instruction;
    logic [15:0] mem_address;
    logic [7:0]  mem_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        halted;
    logic        reg_write_valid;
    logic [4:0]  reg_write_index;
    logic [31:0] reg_write_value;
    logic [7:0]  read_byte;
  } out_word_t;

  typedef struct packed {
    logic [XLEN-1:0]      npc;
    logic                 halted;
    logic                 wr;
    logic [REG_IDX_W-1:0] widx;
    logic [XLEN-1:0]      val;
    logic                 is_load;
    logic                 is_rdbyte;
  } ex_res_t;

  typedef struct packed {
    logic en;
    logic we;
    logic word;
  } mem_ctl_t;

endpackage

// ----- hw/rtl/rssc_regfile.sv -----
// Register file: 32 entries, two registered read ports with write bypass, reset to zero.
`timescale 1ns / 1ps

module rssc_regfile (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            rd_en_i,
  input  logic [rssc_pkg::REG_IDX_W-1:0]  rd_addr_a_i,
  input  logic [rssc_pkg::REG_IDX_W-1:0]  rd_addr_b_i,
  output logic [rssc_pkg::XLEN-1:0]       rd_data_a_o,
  output logic [rssc_pkg::XLEN-1:0]       rd_data_b_o,
  input  logic                            wr_en_i,
  input  logic [rssc_pkg::REG_IDX_W-1:0]  wr_addr_i,
  input  logic [rssc_pkg::XLEN-1:0]       wr_data_i
);

  logic [rssc_pkg::XLEN-1:0]     mem_q [rssc_pkg::NUM_REGS];
  logic [rssc_pkg::NUM_REGS-1:0] vld_q;
  logic [rssc_pkg::XLEN-1:0]     rd_a_d, rd_a_q, rd_b_d, rd_b_q;

  always_comb begin
    if (wr_en_i && wr_addr_i == rd_addr_a_i) begin
      rd_a_d = wr_data_i;
    end else if (vld_q[rd_addr_a_i]) begin
      rd_a_d = mem_q[rd_addr_a_i];
    end else begin
      rd_a_d = '0;
    end
    if (wr_en_i && wr_addr_i == rd_addr_b_i) begin
      rd_b_d = wr_data_i;
    end else if (vld_q[rd_addr_b_i]) begin
      rd_b_d = mem_q[rd_addr_b_i];
    end else begin
      rd_b_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_a_q <= rd_a_d;
      rd_b_q <= rd_b_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

// ----- hw/rtl/rssc_dmem.sv -----
// Data memory: four byte banks, big-endian word or byte access at any byte address.
`timescale 1ns / 1ps

module rssc_dmem #(
  parameter int unsigned DataAddrWidth = rssc_pkg::DATA_ADDR_W
) (
  input  logic                         clk_i,
  input  rssc_pkg::mem_ctl_t           ctl_i,
  input  logic [DataAddrWidth-1:0]     addr_i,
  input  logic [rssc_pkg::XLEN-1:0]    wdata_i,
  output logic [rssc_pkg::XLEN-1:0]    rdata_o
);

  localparam int unsigned RowW = DataAddrWidth - 2;
  localparam int unsigned Rows = 1 << RowW;

  logic [1:0]      off;
  logic [1:0]      off_q;
  logic [RowW-1:0] row, row_nx;
  logic [7:0]      rd_bytes [4];

  assign off    = addr_i[1:0];
  assign row    = addr_i[DataAddrWidth-1:2];
  assign row_nx = row + 1'b1;

  for (genvar k = 0; k < 4; k++) begin : g_bank
    localparam logic [1:0] Bank = 2'(k);
    logic [1:0]      lane;
    logic [RowW-1:0] bank_row;
    logic [7:0]      bank_wd;
    logic            bank_we;
    logic [7:0]      bank_q [Rows];
    logic [7:0]      bank_rd_q;

    assign lane     = Bank - off;
    assign bank_row = (Bank < off) ? row_nx : row;
    assign bank_wd  = wdata_i[{~lane, 3'b000} +: 8];
    assign bank_we  = ctl_i.en && ctl_i.we && (ctl_i.word || lane == 2'd0);

    always_ff @(posedge clk_i) begin
      if (bank_we) begin
        bank_q[bank_row] <= bank_wd;
      end
      if (ctl_i.en) begin
        bank_rd_q <= bank_q[bank_row];
      end
    end

    assign rd_bytes[k] = bank_rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      off_q <= off;
    end
  end

  assign rdata_o = {rd_bytes[off_q], rd_bytes[off_q + 2'd1],
                    rd_bytes[off_q + 2'd2], rd_bytes[off_q + 2'd3]};

endmodule

// ----- hw/rtl/rssc_exec.sv -----
// Execute logic: decode, ALU, branch and jump target, memory request for one word.
`timescale 1ns / 1ps

module rssc_exec #(
  parameter int unsigned DataAddrWidth = rssc_pkg::DATA_ADDR_W
) (
  input  rssc_pkg::in_word_t          item_i,
  input  logic [rssc_pkg::XLEN-1:0]   rs_val_i,
  input  logic [rssc_pkg::XLEN-1:0]   rt_val_i,
  input  logic [rssc_pkg::XLEN-1:0]   pc_i,
  input  logic                        halted_i,
  output rssc_pkg::ex_res_t           res_o,
  output rssc_pkg::mem_ctl_t          mem_ctl_o,
  output logic [DataAddrWidth-1:0]    mem_addr_o,
  output logic [rssc_pkg::XLEN-1:0]   mem_wdata_o
);

  logic [5:0]                     op;
  logic [2:0]                     funct;
  logic [rssc_pkg::REG_IDX_W-1:0] rt_idx, rd_idx;
  logic [rssc_pkg::XLEN-1:0]      sext, pc4, eff;

  assign op     = item_i.instruction[31:26];
  assign funct  = item_i.instruction[2:0];
  assign rt_idx = item_i.instruction[20:16];
  assign rd_idx = item_i.instruction[15:11];
  assign sext   = {{16{item_i.instruction[15]}}, item_i.instruction[15:0]};
  assign pc4    = pc_i + 32'd4;
  assign eff    = rs_val_i + sext;

  always_comb begin
    logic                           wr;
    logic                           ld;
    logic [rssc_pkg::REG_IDX_W-1:0] widx;
    logic [rssc_pkg::XLEN-1:0]      val;

    wr          = 1'b0;
    ld          = 1'b0;
    widx        = '0;
    val         = '0;
    res_o       = '0;
    res_o.npc   = pc_i;
    res_o.halted = halted_i;
    mem_ctl_o   = '0;
    mem_addr_o  = item_i.mem_address[DataAddrWidth-1:0];
    mem_wdata_o = {item_i.mem_byte, 24'd0};

    unique case (item_i.action)
      rssc_pkg::ACT_WRITE: begin
        mem_ctl_o.en = 1'b1;
        mem_ctl_o.we = 1'b1;
      end
      rssc_pkg::ACT_READ: begin
        mem_ctl_o.en    = 1'b1;
        res_o.is_rdbyte = 1'b1;
      end
      rssc_pkg::ACT_EXEC: begin
        if (!halted_i) begin
          if (item_i.instruction == rssc_pkg::HALT_WORD) begin
            res_o.halted = 1'b1;
          end else begin
            res_o.npc = pc4;
            unique case (op)
              rssc_pkg::OP_RTYPE: begin
                widx = rd_idx;
                wr   = 1'b1;
                unique case (funct)
                  rssc_pkg::FN_ADDU: val = rs_val_i + rt_val_i;
                  rssc_pkg::FN_SUBU: val = rs_val_i - rt_val_i;
                  rssc_pkg::FN_AND:  val = rs_val_i & rt_val_i;
                  rssc_pkg::FN_OR:   val = rs_val_i | rt_val_i;
                  rssc_pkg::FN_NOR:  val = ~(rs_val_i | rt_val_i);
                  default:           wr  = 1'b0;
                endcase
              end
              rssc_pkg::OP_J: begin
                res_o.npc = {pc4[31:28], item_i.instruction[25:0], 2'b00};
              end
              rssc_pkg::OP_LW: begin
                mem_ctl_o.en   = 1'b1;
                mem_ctl_o.word = 1'b1;
                mem_addr_o     = eff[DataAddrWidth-1:0];
                wr             = 1'b1;
                ld             = 1'b1;
                widx           = rt_idx;
              end
              rssc_pkg::OP_SW: begin
                mem_ctl_o.en   = 1'b1;
                mem_ctl_o.we   = 1'b1;
                mem_ctl_o.word = 1'b1;
                mem_addr_o     = eff[DataAddrWidth-1:0];
                mem_wdata_o    = rt_val_i;
              end
              rssc_pkg::OP_ADDIU: begin
                wr   = 1'b1;
                widx = rt_idx;
                val  = eff;
              end
              default: begin
                if (rs_val_i == rt_val_i) begin
                  res_o.npc = pc4 + {sext[29:0], 2'b00};
                end
              end
            endcase
          end
        end
      end
      default: ;
    endcase

    if (wr && widx == '0) begin
      wr = 1'b0;
    end
    res_o.wr      = wr;
    res_o.widx    = wr ? widx : '0;
    res_o.val     = (wr && !ld) ? val : '0;
    res_o.is_load = wr && ld;
  end

endmodule

// ----- hw/rtl/risc_subset_single_cycle_core.sv -----
// Top level of the subset core: input stage, execute/memory stage, output register.
//
//   channel  | handshake                | word
//   ---------+--------------------------+------------------------------
//   in       | in_valid_i / in_ready_o  | in_word_i  (rssc_pkg::in_word_t)
//   out      | out_valid_o / out_ready_i| out_word_o (rssc_pkg::out_word_t)
//
// One word per cycle sustained unless the output stalls; a result is offered from the
// output register after its word passes the operand read and memory access registers.
// The register file read and the data memory bank read are each registered.
// Results of the word ahead are forwarded, so dependent words issue back to back.
// Reset clears pc, halt flag, register file valid bits and stage valids; no clearing pass.
// A stalled output holds; empty stages still fill, so input stays ready until all are full.
`timescale 1ns / 1ps

module risc_subset_single_cycle_core #(
  parameter int unsigned DataAddrWidth = rssc_pkg::DATA_ADDR_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rssc_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rssc_pkg::out_word_t out_word_o
);

  logic en1, en2, en_out, accept, adv1, adv2;

  logic                      v1_q, v2_q, ov_q;
  rssc_pkg::in_word_t        item_q;
  rssc_pkg::ex_res_t         s2_q, ex_res;
  rssc_pkg::out_word_t       out_q;
  logic [rssc_pkg::XLEN-1:0] pc_q;
  logic                      halt_q;

  logic [rssc_pkg::XLEN-1:0] rf_a, rf_b, op_a, op_b, s2_val, dm_rdata, dm_wdata;
  logic [4:0]                rs_q_idx, rt_q_idx;
  rssc_pkg::mem_ctl_t        ex_mem_ctl, dm_ctl;
  logic [DataAddrWidth-1:0]  dm_addr;

  assign en_out     = !ov_q || out_ready_i;
  assign en2        = !v2_q || en_out;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;
  assign accept     = in_valid_i && en1;
  assign adv1       = v1_q && en2;
  assign adv2       = v2_q && en_out;

  rssc_regfile u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_addr_a_i (in_word_i.instruction[25:21]),
    .rd_addr_b_i (in_word_i.instruction[20:16]),
    .rd_data_a_o (rf_a),
    .rd_data_b_o (rf_b),
    .wr_en_i     (adv2 && s2_q.wr),
    .wr_addr_i   (s2_q.widx),
    .wr_data_i   (s2_val)
  );

  assign s2_val   = s2_q.is_load ? dm_rdata : s2_q.val;
  assign rs_q_idx = item_q.instruction[25:21];
  assign rt_q_idx = item_q.instruction[20:16];
  assign op_a     = (v2_q && s2_q.wr && s2_q.widx == rs_q_idx) ? s2_val : rf_a;
  assign op_b     = (v2_q && s2_q.wr && s2_q.widx == rt_q_idx) ? s2_val : rf_b;

  rssc_exec #(
    .DataAddrWidth (DataAddrWidth)
  ) u_exec (
    .item_i      (item_q),
    .rs_val_i    (op_a),
    .rt_val_i    (op_b),
    .pc_i        (pc_q),
    .halted_i    (halt_q),
    .res_o       (ex_res),
    .mem_ctl_o   (ex_mem_ctl),
    .mem_addr_o  (dm_addr),
    .mem_wdata_o (dm_wdata)
  );

  always_comb begin
    dm_ctl    = ex_mem_ctl;
    dm_ctl.en = ex_mem_ctl.en && adv1;
  end

  rssc_dmem #(
    .DataAddrWidth (DataAddrWidth)
  ) u_dmem (
    .clk_i   (clk_i),
    .ctl_i   (dm_ctl),
    .addr_i  (dm_addr),
    .wdata_i (dm_wdata),
    .rdata_o (dm_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      ov_q   <= 1'b0;
      pc_q   <= '0;
      halt_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en_out) begin
        ov_q <= v2_q;
      end
      if (adv1) begin
        pc_q   <= ex_res.npc;
        halt_q <= ex_res.halted;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_word_i;
    end
    if (adv1) begin
      s2_q <= ex_res;
    end
    if (adv2) begin
      out_q.next_pc         <= s2_q.npc;
      out_q.halted          <= s2_q.halted;
      out_q.reg_write_valid <= s2_q.wr;
      out_q.reg_write_index <= s2_q.widx;
      out_q.reg_write_value <= s2_val;
      out_q.read_byte       <= s2_q.is_rdbyte ? dm_rdata[31:24] : 8'd0;
    end
  end

  assign out_valid_o = ov_q;
  assign out_word_o  = out_q;

endmodule

// ----- hw/rtl/rssc_checker.sv -----
// Port-level checker for the subset core, bound to the top level.
`timescale 1ns / 1ps

module rssc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input rssc_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input rssc_pkg::out_word_t out_word_o
);

  logic        in_acc, out_acc;
  logic [2:0]  cnt_q;
  logic        halt_seen_q;
  logic [31:0] halt_pc_q;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      halt_seen_q <= 1'b0;
      halt_pc_q   <= '0;
    end else begin
      cnt_q <= cnt_q + 3'(in_acc) - 3'(out_acc);
      if (out_acc && out_word_o.halted) begin
        halt_seen_q <= 1'b1;
        halt_pc_q   <= out_word_o.next_pc;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != 3'd0)
    else $error("result without an accepted input word");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && halt_seen_q |->
      out_word_o.halted && out_word_o.next_pc == halt_pc_q && !out_word_o.reg_write_valid)
    else $error("core left halt state");

  a_wr_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_word_o.reg_write_valid && out_word_o.reg_write_index != 5'd0) ||
      (!out_word_o.reg_write_valid && out_word_o.reg_write_index == 5'd0 &&
       out_word_o.reg_write_value == 32'd0))
    else $error("inconsistent register write fields");

endmodule

bind risc_subset_single_cycle_core rssc_checker u_rssc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
